FILE: src/assert_macros.svh
// Assertion helpers for the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion lbl failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion lbl failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: src/scsf_pkg.sv
package scsf_pkg;

    localparam int NUM_STRIPS  = 4096;
    localparam int SIDE_STRIPS = 1024;
    localparam int IDX_W       = 12;
    localparam int POS_W       = IDX_W + 1;
    localparam int SIDE_W      = $clog2(SIDE_STRIPS);

    localparam logic [15:0] FIND_THR_RST    = 16'd768;
    localparam logic [15:0] CLUSTER_THR_RST = 16'd1024;

    // Register select is bit 2 of the byte address.
    localparam logic REG_FIND    = 1'b0;
    localparam logic REG_CLUSTER = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [11:0]        strip_index;
        logic signed [15:0] signal;
        logic [15:0]        noise;
        logic               channel_good;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] seed_channel;
        logic [11:0] neighbour_channel;
    } result_t;

    typedef struct packed {
        logic        good;
        logic [15:0] sig;
        logic [15:0] noise;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_CLIMB_RD,
        ST_CLIMB_LD,
        ST_CLIMB_CMP,
        ST_NB_SEL,
        ST_NB_LD1,
        ST_NB_LD2,
        ST_NB_CMP,
        ST_NB_ONE,
        ST_PAIR1,
        ST_PAIR2,
        ST_PAIR3,
        ST_PAIR4
    } state_t;

endpackage

FILE: src/scsf_ram.sv
module scsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/strip_cluster_seed_finder_unit.sv
// Strip cluster seed finder.
// Input beats (item_valid/item_ready) are loads or fetches. A load writes one
// strip's signal, noise and good bit into the strip memory and rewinds the
// scan to strip 0; it returns no result. A fetch resumes the scan and returns
// exactly one result beat (result_valid/result_ready): a seed and its
// neighbour, or found = 0 once the scan has passed the last strip.
// A fetch steps through the seed test per strip, the climb, the neighbour
// choice and the pair test, all serialised by the single read port of the
// strip memory and the shared product registers. Only one fetch is in
// flight at a time; a load or fetch is taken in the idle state while the
// result register is free or being emptied in the same cycle. A stalled
// receiver holds the result register and blocks further fetches. Reset
// clears the scan position and the result valid flag and restores the
// thresholds (768 and 1024); the strip memory is not cleared and must be
// loaded before it is scanned. Thresholds are written over the APB port;
// the user must write them only while idle, the block does not enforce it.
module strip_cluster_seed_finder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  scsf_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_ready,
    output scsf_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import scsf_pkg::*;
    `include "assert_macros.svh"

    state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] m_reg, m_next, nm_reg, nm_next, nb_reg, nb_next;
    logic [1:0] k_reg, k_next;
    logic moved_reg, moved_next;
    logic signed [15:0] best_num_reg, best_num_next, nba_num_reg, nba_num_next;
    logic signed [15:0] cand_num_reg, cand_num_next;
    logic [15:0] best_den_reg, best_den_next, nba_den_reg, nba_den_next;
    logic [15:0] cand_den_reg, cand_den_next;
    logic best_good_reg, best_good_next, nba_good_reg, nba_good_next;
    logic cand_good_reg, cand_good_next;
    logic signed [32:0] p1_reg, p1_next, p2_reg, p2_next;
    logic s_neg_reg, s_neg_next;
    logic [31:0] s2_reg, s2_next, da2_reg, da2_next, db2_reg, db2_next;
    logic [31:0] c2_reg, c2_next;
    logic [32:0] q_reg, q_next;
    logic [48:0] plo_reg, plo_next, phi_reg, phi_next;
    result_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] ft_reg, ct_reg;

    entry_t ram_rdata, ram_wdata;
    logic ram_we;
    logic [IDX_W-1:0] ram_raddr;

    logic signed [15:0] dec_num;
    logic [15:0] dec_den;
    logic signed [33:0] seed_lhs, seed_rhs;
    logic seed_pass;
    logic [POS_W-1:0] m_ext, j_pos, m_plus3;
    logic [SIDE_W-1:0] sc, side_rem;
    logic climb_go;
    logic signed [15:0] mx_num, my_num;
    logic [15:0] mx_den, my_den;
    logic signed [17:0] s_sum;
    logic [64:0] q_prod;
    logic [64:0] s_lhs;
    logic item_acc, cfg_wr;

    scsf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_STRIPS)
    ) u_strip_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(item.strip_index),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign item_acc     = item_valid && item_ready;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign prdata       = {16'd0, (paddr[2] == REG_CLUSTER) ? ct_reg : ft_reg};

    assign ram_wdata.good  = item.channel_good;
    assign ram_wdata.sig   = item.signal;
    assign ram_wdata.noise = item.noise;
    assign ram_we = item_acc && (item.mode == MODE_LOAD)
                    && ({1'b0, item.strip_index} < POS_W'(NUM_STRIPS));

    // Masked signal and noise floor of the word just read.
    assign dec_num  = ram_rdata.good ? $signed(ram_rdata.sig) : 16'sd0;
    assign dec_den  = (ram_rdata.noise == 16'd0) ? 16'd1 : ram_rdata.noise;
    assign seed_lhs = {{6{dec_num[15]}}, dec_num, 12'd0};
    assign seed_rhs = $signed({2'b00, 32'(ft_reg) * 32'(dec_den)});
    assign seed_pass = !(seed_lhs < seed_rhs);

    assign m_ext    = {1'b0, m_reg};
    assign j_pos    = m_ext + POS_W'(k_reg);
    assign m_plus3  = m_ext + POS_W'(3);
    assign sc       = m_reg[SIDE_W-1:0];
    assign side_rem = SIDE_W'(SIDE_STRIPS - 1) - sc;
    assign climb_go = (k_reg != 2'd3) && (SIDE_W'(k_reg) <= side_rem)
                      && (j_pos < POS_W'(NUM_STRIPS));

    // Cross products for the signal-to-noise order, x greater than y.
    always_comb
    begin
        if (state_reg == ST_NB_LD2)
        begin
            mx_num = nba_num_reg;
            mx_den = nba_den_reg;
            my_num = dec_num;
            my_den = dec_den;
        end
        else
        begin
            mx_num = dec_num;
            mx_den = dec_den;
            my_num = best_num_reg;
            my_den = best_den_reg;
        end
    end

    assign s_sum  = 18'(best_num_reg) + 18'(nba_num_reg);
    assign q_prod = {phi_reg, 16'd0} + 65'(plo_reg);
    assign s_lhs  = 65'({s2_reg, 24'd0});

    always_comb
    begin
        unique case (state_reg)
            ST_SEED_RD:  ram_raddr = pos_reg[IDX_W-1:0];
            ST_CLIMB_RD: ram_raddr = j_pos[IDX_W-1:0];
            ST_NB_SEL:   ram_raddr = ((m_plus3 - POS_W'(2)) >= POS_W'(NUM_STRIPS)
                                      || sc == SIDE_W'(SIDE_STRIPS - 1) || sc != '0)
                                     ? m_reg - IDX_W'(1) : m_reg + IDX_W'(1);
            ST_NB_LD1:   ram_raddr = m_reg + IDX_W'(1);
            default:     ram_raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        m_next         = m_reg;
        nm_next        = nm_reg;
        nb_next        = nb_reg;
        k_next         = k_reg;
        moved_next     = moved_reg;
        best_num_next  = best_num_reg;
        best_den_next  = best_den_reg;
        best_good_next = best_good_reg;
        nba_num_next   = nba_num_reg;
        nba_den_next   = nba_den_reg;
        nba_good_next  = nba_good_reg;
        cand_num_next  = cand_num_reg;
        cand_den_next  = cand_den_reg;
        cand_good_next = cand_good_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        s_neg_next     = s_neg_reg;
        s2_next        = s2_reg;
        da2_next       = da2_reg;
        db2_next       = db2_reg;
        c2_next        = c2_reg;
        q_next         = q_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.mode == MODE_LOAD)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SEED_RD;
                    end
                end
            end
            ST_SEED_RD:
            begin
                if (pos_reg >= POS_W'(NUM_STRIPS))
                begin
                    pos_next       = POS_W'(NUM_STRIPS);
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SEED_CHK;
                end
            end
            ST_SEED_CHK:
            begin
                if (seed_pass)
                begin
                    best_num_next  = dec_num;
                    best_den_next  = dec_den;
                    best_good_next = ram_rdata.good;
                    m_next         = pos_reg[IDX_W-1:0];
                    nm_next        = pos_reg[IDX_W-1:0];
                    start_next     = pos_reg;
                    k_next         = 2'd1;
                    moved_next     = 1'b0;
                    state_next     = ST_CLIMB_RD;
                end
                else
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = ST_SEED_RD;
                end
            end
            ST_CLIMB_RD:
            begin
                if (climb_go)
                begin
                    state_next = ST_CLIMB_LD;
                end
                else if (moved_reg)
                begin
                    m_next     = nm_reg;
                    k_next     = 2'd1;
                    moved_next = 1'b0;
                end
                else
                begin
                    state_next = ST_NB_SEL;
                end
            end
            ST_CLIMB_LD:
            begin
                p1_next        = mx_num * $signed({1'b0, my_den});
                p2_next        = my_num * $signed({1'b0, mx_den});
                cand_num_next  = dec_num;
                cand_den_next  = dec_den;
                cand_good_next = ram_rdata.good;
                state_next     = ST_CLIMB_CMP;
            end
            ST_CLIMB_CMP:
            begin
                if (p1_reg > p2_reg)
                begin
                    best_num_next  = cand_num_reg;
                    best_den_next  = cand_den_reg;
                    best_good_next = cand_good_reg;
                    nm_next        = j_pos[IDX_W-1:0];
                    moved_next     = 1'b1;
                end
                k_next     = k_reg + 2'd1;
                state_next = ST_CLIMB_RD;
            end
            ST_NB_SEL:
            begin
                // At the last strip, or at the top of a side, the partner lies
                // below; at the bottom of a side it lies above.
                if ((m_plus3 - POS_W'(2)) >= POS_W'(NUM_STRIPS)
                    || sc == SIDE_W'(SIDE_STRIPS - 1))
                begin
                    nb_next    = m_reg - IDX_W'(1);
                    state_next = ST_NB_ONE;
                end
                else if (sc == '0)
                begin
                    nb_next    = m_reg + IDX_W'(1);
                    state_next = ST_NB_ONE;
                end
                else
                begin
                    nb_next    = m_reg - IDX_W'(1);
                    state_next = ST_NB_LD1;
                end
            end
            ST_NB_ONE:
            begin
                nba_num_next  = dec_num;
                nba_den_next  = dec_den;
                nba_good_next = ram_rdata.good;
                state_next    = ST_PAIR1;
            end
            ST_NB_LD1:
            begin
                nba_num_next  = dec_num;
                nba_den_next  = dec_den;
                nba_good_next = ram_rdata.good;
                state_next    = ST_NB_LD2;
            end
            ST_NB_LD2:
            begin
                p1_next        = mx_num * $signed({1'b0, my_den});
                p2_next        = my_num * $signed({1'b0, mx_den});
                cand_num_next  = dec_num;
                cand_den_next  = dec_den;
                cand_good_next = ram_rdata.good;
                state_next     = ST_NB_CMP;
            end
            ST_NB_CMP:
            begin
                if (!(p1_reg > p2_reg))
                begin
                    nba_num_next  = cand_num_reg;
                    nba_den_next  = cand_den_reg;
                    nba_good_next = cand_good_reg;
                    nb_next       = m_reg + IDX_W'(1);
                end
                state_next = ST_PAIR1;
            end
            ST_PAIR1:
            begin
                s_neg_next = s_sum[17];
                s2_next    = s_sum[15:0] * s_sum[15:0];
                da2_next   = best_good_reg ? best_den_reg * best_den_reg : 32'd0;
                db2_next   = nba_good_reg ? nba_den_reg * nba_den_reg : 32'd0;
                c2_next    = ct_reg * ct_reg;
                state_next = ST_PAIR2;
            end
            ST_PAIR2:
            begin
                q_next     = 33'(da2_reg) + 33'(db2_reg);
                state_next = ST_PAIR3;
            end
            ST_PAIR3:
            begin
                plo_next   = q_reg * c2_reg[15:0];
                phi_next   = q_reg * c2_reg[31:16];
                state_next = ST_PAIR4;
            end
            ST_PAIR4:
            begin
                // Q * C^2 <= S^2 * 2^24 is the estimator test without the root.
                if (!s_neg_reg && (q_prod <= s_lhs))
                begin
                    out_next.found             = 1'b1;
                    out_next.seed_channel      = m_reg;
                    out_next.neighbour_channel = nb_reg;
                    out_valid_next             = 1'b1;
                    pos_next   = (m_plus3 > POS_W'(NUM_STRIPS)) ? POS_W'(NUM_STRIPS)
                                                                : m_plus3;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = start_reg + POS_W'(3);
                    state_next = ST_SEED_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            ft_reg        <= FIND_THR_RST;
            ct_reg        <= CLUSTER_THR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && paddr[2] == REG_FIND)
            begin
                ft_reg <= pwdata[15:0];
            end
            if (cfg_wr && paddr[2] == REG_CLUSTER)
            begin
                ct_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        m_reg         <= m_next;
        nm_reg        <= nm_next;
        nb_reg        <= nb_next;
        k_reg         <= k_next;
        moved_reg     <= moved_next;
        best_num_reg  <= best_num_next;
        best_den_reg  <= best_den_next;
        best_good_reg <= best_good_next;
        nba_num_reg   <= nba_num_next;
        nba_den_reg   <= nba_den_next;
        nba_good_reg  <= nba_good_next;
        cand_num_reg  <= cand_num_next;
        cand_den_reg  <= cand_den_next;
        cand_good_reg <= cand_good_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        s_neg_reg     <= s_neg_next;
        s2_reg        <= s2_next;
        da2_reg       <= da2_next;
        db2_reg       <= db2_next;
        c2_reg        <= c2_next;
        q_reg         <= q_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        out_reg       <= out_next;
    end

    `ASSERT_NEVER(a_ram_write_busy, clk, rst_n, ram_we && state_reg != ST_IDLE)
    `ASSERT_NEVER(a_seed_is_partner, clk, rst_n, out_valid_reg && out_reg.found && out_reg.seed_channel == out_reg.neighbour_channel)
    `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg > POS_W'(NUM_STRIPS + 2))
    `ASSERT_HOLDS(a_end_zero, clk, rst_n, (out_valid_reg && !out_reg.found) |-> (out_reg.seed_channel == '0 && out_reg.neighbour_channel == '0))

endmodule

FILE: tb/strip_cluster_seed_finder_unit_tb.sv
module strip_cluster_seed_finder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scsf_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    class seed_scoreboard;
        logic [15:0] sig_mem [NUM_STRIPS];
        logic [15:0] noise_mem [NUM_STRIPS];
        bit          good_mem [NUM_STRIPS];
        int unsigned scan_pos;
        int unsigned find_thr;
        int unsigned clus_thr;
        result_t     seeds_due [$];
        int          mismatches;

        function new();
            scan_pos = 0;
            find_thr = FIND_THR_RST;
            clus_thr = CLUSTER_THR_RST;
            mismatches = 0;
        endfunction

        function longint sn_num(int unsigned i);
            return good_mem[i] ? longint'($signed(sig_mem[i])) : 0;
        endfunction

        function longint sn_den(int unsigned i);
            return (noise_mem[i] == 16'd0) ? 1 : longint'(noise_mem[i]);
        endfunction

        function bit sn_above(int unsigned a, int unsigned b);
            return sn_num(a) * sn_den(b) > sn_num(b) * sn_den(a);
        endfunction

        // Signal sum over root of summed noise squares, compared without a root.
        function bit pair_ok(int unsigned a, int unsigned b);
            longint s;
            longint unsigned q;
            longint unsigned lhs;
            longint unsigned c2;
            s = 0;
            q = 0;
            if (good_mem[a])
            begin
                s += sn_num(a);
                q += longint'(sn_den(a) * sn_den(a));
            end
            if (good_mem[b])
            begin
                s += sn_num(b);
                q += longint'(sn_den(b) * sn_den(b));
            end
            if (s < 0)
                return 0;
            lhs = (longint'(s) * longint'(s)) << 24;
            c2 = longint'(clus_thr) * longint'(clus_thr);
            if (c2 == 0)
                return 1;
            return q <= lhs / c2;
        endfunction

        function result_t next_seed();
            result_t     r;
            int unsigned pos;
            int unsigned m;
            int unsigned nm;
            int unsigned nb;
            int unsigned ext;
            int unsigned j;
            r = '0;
            pos = scan_pos;
            while (pos < NUM_STRIPS)
            begin
                if (4096 * sn_num(pos) < longint'(find_thr) * sn_den(pos))
                begin
                    pos++;
                    continue;
                end
                m = pos;
                forever
                begin
                    nm = m;
                    ext = SIDE_STRIPS - 1 - (m % SIDE_STRIPS);
                    if (ext > 2)
                        ext = 2;
                    for (int unsigned k = 1; k <= ext; k++)
                    begin
                        j = m + k;
                        if (j >= NUM_STRIPS)
                            break;
                        if (sn_above(j, nm))
                            nm = j;
                    end
                    if (nm == m)
                        break;
                    m = nm;
                end
                if (m + 1 >= NUM_STRIPS)
                    nb = m - 1;
                else if (m % SIDE_STRIPS == 0)
                    nb = m + 1;
                else if (m % SIDE_STRIPS == SIDE_STRIPS - 1)
                    nb = m - 1;
                else
                    nb = sn_above(m - 1, m + 1) ? m - 1 : m + 1;
                if (pair_ok(m, nb))
                begin
                    r.found = 1'b1;
                    r.seed_channel = m[11:0];
                    r.neighbour_channel = nb[11:0];
                    scan_pos = (m + 3 > NUM_STRIPS) ? NUM_STRIPS : m + 3;
                    return r;
                end
                pos += 3;
            end
            scan_pos = NUM_STRIPS;
            return r;
        endfunction

        function void note_item(item_t it);
            if (it.mode == MODE_LOAD)
            begin
                sig_mem[it.strip_index] = it.signal;
                noise_mem[it.strip_index] = it.noise;
                good_mem[it.strip_index] = it.channel_good;
                scan_pos = 0;
            end
            else
                seeds_due.insert(seeds_due.size(), next_seed());
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (seeds_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            want = seeds_due.pop_front();
            if (got.found !== want.found || got.seed_channel !== want.seed_channel
                || got.neighbour_channel !== want.neighbour_channel)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_ready;
    result_t result;
    logic    result_valid;
    logic    result_ready;
    logic    psel;
    logic    penable;
    logic    pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic    pready;

    seed_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic recv_hold;
    longint cycles;

    strip_cluster_seed_finder_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .item(item), .item_valid(item_valid), .item_ready(item_ready),
        .result(result), .result_valid(result_valid), .result_ready(result_ready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("strip_cluster_seed_finder_unit_tb failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when recv_hold is set.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_result(result);
            result_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
    endtask

    task automatic reg_write(input logic sel, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_FIND)
            sb.find_thr = value;
        else
            sb.clus_thr = value;
    endtask

    // Loads return nothing, so idle cycles follow the last result.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.seeds_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic item_t load_beat(input int idx);
        item_t it;
        int    pick;
        it = '0;
        it.mode = MODE_LOAD;
        it.strip_index = idx[11:0];
        it.channel_good = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            it.signal = 16'($urandom_range(8000, 400));
            it.noise = 16'($urandom_range(1024, 256));
        end
        else if (pick < 20)
        begin
            it.signal = 16'($urandom);
            it.noise = 16'($urandom);
        end
        else
        begin
            it.signal = 16'($signed($urandom_range(128)) - 64);
            it.noise = 16'($urandom_range(1024, 256));
        end
        return it;
    endfunction

    function automatic item_t fetch_beat();
        item_t it;
        it = item_t'({$urandom, $urandom});
        it.mode = MODE_FETCH;
        return it;
    endfunction

    task automatic random_traffic(input int n_items);
        int sent;
        int n_fetch;
        int idx;
        sent = 0;
        while (sent < n_items)
        begin
            repeat ($urandom_range(3, 1))
            begin
                case ($urandom_range(9))
                    0: idx = 0;
                    1: idx = NUM_STRIPS - 1;
                    2: idx = SIDE_STRIPS - 1 + $urandom_range(1);
                    default: idx = $urandom_range(NUM_STRIPS - 1);
                endcase
                send_item(load_beat(idx));
                sent++;
            end
            n_fetch = ($urandom_range(7) == 0) ? 250 : $urandom_range(40, 1);
            repeat (n_fetch)
            begin
                send_item(fetch_beat());
                sent++;
            end
        end
    endtask

    task automatic directed_loads();
        item_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.channel_good = 1'b1;
        // Rising strips that run into the end of a side.
        it.strip_index = 1022; it.signal = 16'sd3000; it.noise = 16'd256; send_item(it);
        it.strip_index = 1023; it.signal = 16'sd4000; it.noise = 16'd256; send_item(it);
        it.strip_index = 1024; it.signal = 16'sd8000; it.noise = 16'd256; send_item(it);
        it.strip_index = 1025; it.signal = -16'sd32768; it.noise = 16'd65535; send_item(it);
        // Seed on the very first and very last strips.
        it.strip_index = 0; it.signal = 16'sd32767; it.noise = 16'd0; send_item(it);
        it.strip_index = 4095; it.signal = 16'sd5000; it.noise = 16'd256; send_item(it);
        it.strip_index = 4094; it.signal = 16'sd100; it.noise = 16'd0; send_item(it);
        // A masked pair.
        it.channel_good = 1'b0;
        it.strip_index = 200; it.signal = 16'sd9000; it.noise = 16'd256; send_item(it);
        it.strip_index = 201; it.signal = -16'sd9000; it.noise = 16'd1; send_item(it);
        repeat (14) send_item(fetch_beat());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every strip is written before the first scan reads it.
        for (int i = 0; i < NUM_STRIPS; i++)
            send_item(load_beat(i));
        directed_loads();
        drain();

        reg_write(REG_FIND, 16'd0);
        reg_write(REG_CLUSTER, 16'd0);
        send_idle_pct = 55;
        random_traffic(300);
        drain();

        reg_write(REG_FIND, 16'd65535);
        reg_write(REG_CLUSTER, 16'd65535);
        send_idle_pct = 0;
        recv_stall_pct = 55;
        random_traffic(250);
        drain();

        reg_write(REG_FIND, 16'd1280);
        reg_write(REG_CLUSTER, 16'd512);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        random_traffic(300);
        drain();

        reg_write(REG_FIND, 16'd768);
        reg_write(REG_CLUSTER, 16'd2000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Hold the receiver off while fetches keep coming so the input backs up.
        fork
            begin
                recv_hold <= 1'b1;
                repeat (600) @(posedge clk);
                recv_hold <= 1'b0;
            end
            begin
                repeat (20) send_item(fetch_beat());
            end
        join
        drain();
        random_traffic(300);
        drain();

        if (sb.mismatches == 0 && sb.seeds_due.size() == 0)
            $display("strip_cluster_seed_finder_unit_tb passed");
        else
            $display("strip_cluster_seed_finder_unit_tb failed");
        $finish;
    end

endmodule
